>>> sv/ttcb_pkg.sv
// Package with the shared types and constants of the triggered trace capture buffer.
package ttcb_pkg;

    localparam int unsigned DATA_W = 32;

    typedef struct packed {
        logic [DATA_W-1:0] entry_word;
        logic              is_trigger;
    } entry_req_t;

    typedef struct packed {
        logic [DATA_W-1:0] dump_word;
        logic              trigger_mark;
        logic              last;
    } dump_req_t;

    typedef enum logic [1:0] {
        CFG_TRIGGER_MODE   = 2'd0,
        CFG_CAPTURE_ENABLE = 2'd1,
        CFG_DEPTH_IN_USE   = 2'd2,
        CFG_UNUSED         = 2'd3
    } ttcb_cfg_t;

    typedef enum logic [1:0] {
        MODE_PRE      = 2'd0,
        MODE_MIDDLE   = 2'd1,
        MODE_POST     = 2'd2,
        MODE_RESERVED = 2'd3
    } ttcb_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT,
        ST_CAPTURE,
        ST_PREP,
        ST_DUMP,
        ST_STOP
    } ttcb_state_t;

    typedef struct packed {
        logic write;
        logic start_dump;
        logic dump_run;
    } ttcb_cmd_t;

    typedef struct packed {
        logic rearm;
        logic arm_enable;
        logic arm_wait;
        logic stop_hit;
        logic dump_empty;
    } ttcb_status_t;

endpackage

>>> sv/ttcb_datapath.sv
// Datapath with configuration registers, trace ring memory, index logic and dump output register.
module ttcb_datapath #(
    parameter int DEPTH       = 64,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [6:0]           cfg_data,
    input  ttcb_pkg::entry_req_t in_data,
    input  logic                 out_stall,
    output logic                 out_valid,
    output ttcb_pkg::dump_req_t  out_data,
    input  ttcb_pkg::ttcb_cmd_t  cmd,
    output ttcb_pkg::ttcb_status_t status
);
    import ttcb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = (ENTRY_WIDTH < 32) ? ENTRY_WIDTH : 32;

    logic [1:0]    mode_reg, mode_next;
    logic          enable_reg, enable_next;
    logic [6:0]    depth_reg, depth_next;
    logic [AW-1:0] wi_reg, wi_next;
    logic          wrapped_reg, wrapped_next;
    logic          seen_reg, seen_next;
    logic [AW-1:0] stop_idx_reg, stop_idx_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic          out_valid_reg, out_valid_next;
    dump_req_t     out_data_reg;

    logic [SW:0]   mem [DEPTH];
    logic [SW:0]   mem_q_reg;

    logic          rearm;
    logic [CW-1:0] d;
    logic [AW-1:0] last_slot;
    logic [1:0]    mode_eff;
    logic          mark;
    logic          stop_hit;
    logic          set_stop_idx;
    logic [CW:0]   mid_sum;
    logic [AW-1:0] mid_idx;
    logic          load;
    logic [AW-1:0] ptr_inc;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wi_inc;

    always_comb
    begin
        mode_next   = mode_reg;
        enable_next = enable_reg;
        depth_next  = depth_reg;
        rearm       = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_TRIGGER_MODE:
                begin
                    mode_next = cfg_data[1:0];
                    rearm     = 1'b1;
                end
                CFG_CAPTURE_ENABLE:
                begin
                    enable_next = cfg_data[0];
                    rearm       = 1'b1;
                end
                CFG_DEPTH_IN_USE:
                begin
                    depth_next = cfg_data;
                    rearm      = 1'b1;
                end
                default:
                begin
                    rearm = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        if (depth_reg == 7'd0)
        begin
            d = CW'(1);
        end
        else if (32'(depth_reg) > 32'(DEPTH))
        begin
            d = CW'(DEPTH);
        end
        else
        begin
            d = CW'(depth_reg);
        end
    end

    assign last_slot = AW'(d - CW'(1));
    assign mode_eff  = (mode_reg == MODE_RESERVED) ? MODE_PRE : mode_reg;
    assign mid_sum   = (CW + 1)'(wi_reg) + (CW + 1)'(d >> 1);
    assign mid_idx   = (mid_sum > (CW + 1)'(last_slot)) ? AW'(mid_sum - (CW + 1)'(d))
                                                        : AW'(mid_sum);
    assign wi_inc    = (wi_reg == last_slot) ? '0 : AW'(wi_reg + AW'(1));
    assign ptr_inc   = (ptr_reg == last_slot) ? '0 : AW'(ptr_reg + AW'(1));

    always_comb
    begin
        mark         = 1'b0;
        stop_hit     = 1'b0;
        set_stop_idx = 1'b0;
        case (mode_eff)
            MODE_MIDDLE:
            begin
                if (!seen_reg)
                begin
                    mark         = in_data.is_trigger;
                    set_stop_idx = in_data.is_trigger;
                end
                else
                begin
                    stop_hit = (wi_reg == stop_idx_reg);
                end
            end
            MODE_POST:
            begin
                if (!seen_reg)
                begin
                    mark = 1'b1;
                end
                else
                begin
                    stop_hit = (wi_reg == last_slot);
                end
            end
            default:
            begin
                mark     = in_data.is_trigger;
                stop_hit = in_data.is_trigger;
            end
        endcase
    end

    assign load = cmd.dump_run && (rem_reg != '0) && (!out_valid_reg || !out_stall);
    assign rd_addr = load ? ptr_inc : ptr_reg;

    always_comb
    begin
        wi_next        = wi_reg;
        wrapped_next   = wrapped_reg;
        seen_next      = seen_reg;
        stop_idx_next  = stop_idx_reg;
        ptr_next       = ptr_reg;
        rem_next       = rem_reg;
        out_valid_next = out_valid_reg;
        if (rearm)
        begin
            wi_next        = '0;
            wrapped_next   = 1'b0;
            seen_next      = 1'b0;
            stop_idx_next  = '0;
            rem_next       = '0;
            out_valid_next = 1'b0;
        end
        else
        begin
            if (cmd.write)
            begin
                if ((mode_eff == MODE_POST) || set_stop_idx)
                begin
                    seen_next = 1'b1;
                end
                if (set_stop_idx)
                begin
                    stop_idx_next = mid_idx;
                end
                if (cmd.start_dump)
                begin
                    if (wrapped_reg)
                    begin
                        rem_next = d;
                        ptr_next = wi_inc;
                    end
                    else
                    begin
                        rem_next = CW'(wi_reg) + CW'(1);
                        ptr_next = '0;
                    end
                end
                else
                begin
                    wi_next = wi_inc;
                    if (wi_reg == last_slot)
                    begin
                        wrapped_next = 1'b1;
                    end
                end
            end
            if (load)
            begin
                ptr_next       = ptr_inc;
                rem_next       = rem_reg - CW'(1);
                out_valid_next = 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_PRE;
            enable_reg    <= 1'b0;
            depth_reg     <= 7'd64;
            wi_reg        <= '0;
            wrapped_reg   <= 1'b0;
            seen_reg      <= 1'b0;
            stop_idx_reg  <= '0;
            ptr_reg       <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            enable_reg    <= enable_next;
            depth_reg     <= depth_next;
            wi_reg        <= wi_next;
            wrapped_reg   <= wrapped_next;
            seen_reg      <= seen_next;
            stop_idx_reg  <= stop_idx_next;
            ptr_reg       <= ptr_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write && !rearm)
        begin
            mem[wi_reg] <= {mark, in_data.entry_word[SW-1:0]};
        end
        mem_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg.dump_word    <= DATA_W'(mem_q_reg[SW-1:0]);
            out_data_reg.trigger_mark <= mem_q_reg[SW];
            out_data_reg.last         <= (rem_reg == CW'(1));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign status.rearm      = rearm;
    assign status.arm_enable = enable_next;
    assign status.arm_wait   = (mode_next == MODE_POST);
    assign status.stop_hit   = stop_hit;
    assign status.dump_empty = (rem_reg == '0) && (!out_valid_reg || !out_stall);

endmodule

>>> sv/ttcb_controller.sv
// Controller state machine that sequences arming, capture, dump and stop.
module ttcb_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_trigger,
    output logic                   in_stall,
    input  ttcb_pkg::ttcb_status_t status,
    output ttcb_pkg::ttcb_cmd_t    cmd
);
    import ttcb_pkg::*;

    ttcb_state_t state_reg, state_next;
    logic        in_accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_stall       = (state_reg == ST_PREP) || (state_reg == ST_DUMP);
        in_accept      = in_valid && !in_stall;
        cmd.write      = 1'b0;
        cmd.start_dump = 1'b0;
        cmd.dump_run   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_WAIT:
            begin
                if (in_accept && in_trigger)
                begin
                    cmd.write = 1'b1;
                    if (status.stop_hit)
                    begin
                        cmd.start_dump = 1'b1;
                        state_next     = ST_PREP;
                    end
                    else
                    begin
                        state_next = ST_CAPTURE;
                    end
                end
            end
            ST_CAPTURE:
            begin
                if (in_accept)
                begin
                    cmd.write = 1'b1;
                    if (status.stop_hit)
                    begin
                        cmd.start_dump = 1'b1;
                        state_next     = ST_PREP;
                    end
                end
            end
            ST_PREP:
            begin
                state_next = ST_DUMP;
            end
            ST_DUMP:
            begin
                cmd.dump_run = 1'b1;
                if (status.dump_empty)
                begin
                    state_next = ST_STOP;
                end
            end
            ST_STOP:
            begin
                state_next = ST_STOP;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (status.rearm)
        begin
            if (!status.arm_enable)
            begin
                state_next = ST_IDLE;
            end
            else if (status.arm_wait)
            begin
                state_next = ST_WAIT;
            end
            else
            begin
                state_next = ST_CAPTURE;
            end
        end
    end

endmodule

>>> sv/triggered_trace_capture_buffer_unit.sv
// Top level of the triggered trace capture buffer.
// The input channel (in_valid, in_stall, in_data) carries one trace entry per request
// together with its trigger flag. While capturing, an entry is accepted every cycle and
// written into the ring memory in the same cycle; no result is produced for it.
// When the stop condition of the selected trigger mode is met, the block stalls its input,
// primes the registered memory read in its prepare state, and then sends the stored
// entries oldest first on the output channel (out_valid, out_stall, out_data), one request
// per cycle while out_stall is low, with last set on the final one. The input is held
// off for the whole dump, which grows longer while the receiver stalls.
// The single read port of the ring memory sets the dump rate of one entry per cycle.
// After the dump, entries are accepted and dropped until the next configuration write.
// The configuration port (cfg_we, cfg_index, cfg_data) writes trigger mode, capture
// enable and ring depth; each such write re-arms capture. Writes are expected only while
// the block is idle. Reset selects the stop-at-trigger mode, capture disabled and full
// depth; the ring contents are not cleared, since only slots written during the current
// capture are ever read.
module triggered_trace_capture_buffer_unit #(
    parameter int DEPTH       = 64,
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [6:0]           cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  ttcb_pkg::entry_req_t in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output ttcb_pkg::dump_req_t  out_data
);
    import ttcb_pkg::*;

    ttcb_cmd_t    cmd;
    ttcb_status_t status;

    ttcb_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_trigger (in_data.is_trigger),
        .in_stall   (in_stall),
        .status     (status),
        .cmd        (cmd)
    );

    ttcb_datapath #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> sv/ttcb_checker.sv
// Port-level checker for the triggered trace capture buffer and its bind statement.
module ttcb_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_we,
    input logic [1:0]           cfg_index,
    input logic [6:0]           cfg_data,
    input logic                 in_valid,
    input logic                 in_stall,
    input ttcb_pkg::entry_req_t in_data,
    input logic                 out_valid,
    input logic                 out_stall,
    input ttcb_pkg::dump_req_t  out_data
);
    import ttcb_pkg::*;

    // A stalled request holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall && !cfg_we |=> out_valid && $stable(out_data))
        else $error("stalled dump request changed");

    // The input is held off for the whole dump.
    a_dump_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while a dump request is pending");

    // Nothing follows the final request of a dump.
    a_last_ends_dump: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && out_data.last |=> !out_valid)
        else $error("dump request after the last one");

    // A configuration write to a used index re-arms the block and ends any dump.
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index != CFG_UNUSED) |=> !in_stall && !out_valid)
        else $error("block not re-armed after a configuration write");

endmodule

bind triggered_trace_capture_buffer_unit ttcb_checker u_ttcb_checker (.*);
